/* rtl/selective_repeat_send_window_core_defines.svh */
// Assertion macros used by the port checker of the send window core.
`ifndef SELECTIVE_REPEAT_SEND_WINDOW_CORE_DEFINES_SVH
`define SELECTIVE_REPEAT_SEND_WINDOW_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clock and off while reset is high.
`define SRSW_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock and off while reset is high.
`define SRSW_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/srsw_pkg.sv */
// Package with the mark codes, opcodes and fixed widths of the send window core.
package srsw_pkg;

   // Per-slot mark held in the mark store.
   typedef enum logic [1:0] {
      MARK_SENT   = 2'd0,
      MARK_FREE   = 2'd1,
      MARK_RESEND = 2'd2,
      MARK_ACKED  = 2'd3
   } mark_type;

   // Opcodes carried on the request tuser.
   localparam logic [1:0] FUNC_SEND = 2'd0;
   localparam logic [1:0] FUNC_ACK  = 2'd1;
   localparam logic [1:0] FUNC_POLL = 2'd2;

   // Configuration register indexes.
   localparam logic CSR_TOTAL_PACKETS = 1'b0;
   localparam logic CSR_TIMEOUT_POLLS = 1'b1;

   // Fixed widths and reset values.
   localparam int REQ_DATA_W = 8;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 24;
   localparam int CSR_DATA_W = 16;
   localparam logic [7:0]  TIMEOUT_RESET = 8'd20;
   localparam logic [16:0] SENT_MAX = 17'h1FFFF;

endpackage

/* rtl/srsw_mark_store.sv */
// Slot mark memory with per-entry valid bits; an unwritten entry reads as free.
module srsw_mark_store
   import srsw_pkg::*;
#(
   parameter int SEQ_COUNT = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [$clog2(SEQ_COUNT)-1:0] rd_addr,
   output mark_type                     rd_mark,
   input  logic                         wr_en,
   input  logic [$clog2(SEQ_COUNT)-1:0] wr_addr,
   input  mark_type                     wr_data
);

   mark_type               mark_mem_ff [SEQ_COUNT];
   mark_type               rd_data_ff;
   logic                   rd_valid_ff;
   logic [SEQ_COUNT-1:0]   valid_ff;
   logic [SEQ_COUNT-1:0]   valid_in;

   // Memory write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mark_mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mark_mem_ff[rd_addr];
   end

   // A written entry becomes valid; reset clears all of them at once.
   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_mark = rd_valid_ff ? rd_data_ff : MARK_FREE;

endmodule

/* rtl/selective_repeat_send_window_core.sv */
// Top level of the selective-repeat sender window tracker.
//
// Requests arrive on req_: tuser carries the opcode (send, ack, idle poll),
// tdata the raw ack byte. Every request gives exactly one response word on
// rsp_ with the grant, the wire sequence number, the window base and next
// sequence number, the timeout flag and the number of slots marked for resend.
// Write packet budget and poll limit on csr_ only while idle (not enforced).
//
// One request is processed at a time by a small sequencer around the slot mark
// memory, which has one read and one write port. A send reads its slot, then
// checks it and grants if allowed. An ack in the window writes its mark, then
// slides the base over the slots visited (slots slid plus one). A timeout poll
// scans min(WINDOW, SEQ_COUNT) slots; each slot takes a read and a check state.
// Other polls and ignored acks go straight to the response. A new request is
// accepted no sooner than the cycle after the response is loaded.
//
// Reset clears the window, counters and mark valid bits, so every slot reads as
// free afterward. The response sits in an output register: when the receiver
// stalls, the block still takes and processes the next request, then holds it
// in the finish state until the earlier word is taken.
module selective_repeat_send_window_core
   import srsw_pkg::*;
#(
   parameter int SEQ_COUNT = 32,
   parameter int WINDOW    = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   // Request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // [7:0] ack_byte
   input  logic [REQ_USER_W-1:0] req_tuser,  // [1:0] func
   // Response channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [0] send_granted, [6:1] send_seq_wire, [11:7] window_base,
   // [16:12] next_seq, [17] timed_out, [22:18] resend_count, [23] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // Configuration write port
   input  logic                  csr_we,
   input  logic                  csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int SEQ_W = $clog2(SEQ_COUNT);
   localparam int CNT_W = $clog2(SEQ_COUNT + 1);
   localparam int SPAN  = (WINDOW < SEQ_COUNT) ? WINDOW : SEQ_COUNT;

   typedef enum logic [8:0] {
      ST_IDLE      = 9'b000000001,
      ST_DECODE    = 9'b000000010,
      ST_SEND_CHK  = 9'b000000100,
      ST_SLIDE_RD  = 9'b000001000,
      ST_SLIDE_CHK = 9'b000010000,
      ST_SCAN_RD   = 9'b000100000,
      ST_SCAN_CHK  = 9'b001000000,
      ST_FINISH    = 9'b010000000,
      ST_SPARE     = 9'b100000000
   } state_type;

   state_type              state_ff,     state_in;
   logic [SEQ_W-1:0]       base_ff,      base_in;
   logic [SEQ_W-1:0]       send_ff,      send_in;
   logic [16:0]            sent_ff,      sent_in;
   logic [7:0]             wait_ff,      wait_in;
   logic [15:0]            total_ff,     total_in;
   logic [7:0]             timeout_ff,   timeout_in;
   logic [1:0]             func_ff,      func_in;
   logic [7:0]             ack_ff,       ack_in;
   logic [SEQ_W-1:0]       ptr_ff,       ptr_in;
   logic [CNT_W-1:0]       step_ff,      step_in;
   logic [CNT_W-1:0]       cnt_ff,       cnt_in;
   logic                   granted_ff,   granted_in;
   logic [5:0]             wire_ff,      wire_in;
   logic                   tout_ff,      tout_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]  rsp_data_ff,  rsp_data_in;

   logic [SEQ_W-1:0]       rd_addr;
   mark_type               rd_mark;
   logic                   wr_en;
   logic [SEQ_W-1:0]       wr_addr;
   mark_type               wr_data;

   logic [7:0]             ack_idx;
   logic [SEQ_W-1:0]       ack_slot;
   logic                   ack_ok;
   logic [8:0]             poll_next;
   logic [4:0]             resend_sat;

   // Distance from one sequence number forward to another, modulo SEQ_COUNT.
   function automatic logic [SEQ_W-1:0] seq_dist(input logic [SEQ_W-1:0] from_seq,
                                                 input logic [SEQ_W-1:0] to_seq);
      logic [SEQ_W:0] diff;
      diff = {1'b0, to_seq} - {1'b0, from_seq};
      if (diff[SEQ_W]) begin
         diff = diff + (SEQ_W + 1)'(SEQ_COUNT);
      end
      return diff[SEQ_W-1:0];
   endfunction

   // Next sequence number with wraparound.
   function automatic logic [SEQ_W-1:0] seq_inc(input logic [SEQ_W-1:0] seq);
      logic [SEQ_W-1:0] nxt;
      nxt = (seq == SEQ_W'(SEQ_COUNT - 1)) ? '0 : seq + 1'b1;
      return nxt;
   endfunction

   srsw_mark_store #(
      .SEQ_COUNT (SEQ_COUNT)
   ) u_mark_store (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (rd_addr),
      .rd_mark (rd_mark),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   // Ack window test on the captured ack byte.
   assign ack_idx  = ack_ff - 8'd1;
   assign ack_slot = ack_idx[SEQ_W-1:0];
   assign ack_ok   = (ack_ff != 8'd0) && (ack_idx < 8'(SEQ_COUNT)) &&
                     (8'(seq_dist(base_ff, ack_slot)) < 8'(WINDOW));

   assign poll_next  = {1'b0, wait_ff} + 9'd1;
   assign resend_sat = (8'(cnt_ff) > 8'd31) ? 5'd31 : 5'(cnt_ff);

   // Sequencer and datapath next values.
   always_comb begin
      state_in     = state_ff;
      base_in      = base_ff;
      send_in      = send_ff;
      sent_in      = sent_ff;
      wait_in      = wait_ff;
      total_in     = total_ff;
      timeout_in   = timeout_ff;
      func_in      = func_ff;
      ack_in       = ack_ff;
      ptr_in       = ptr_ff;
      step_in      = step_ff;
      cnt_in       = cnt_ff;
      granted_in   = granted_ff;
      wire_in      = wire_ff;
      tout_in      = tout_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rd_addr      = base_ff;
      wr_en        = 1'b0;
      wr_addr      = base_ff;
      wr_data      = MARK_FREE;

      // Configuration writes.
      if (csr_we) begin
         case (csr_addr)
            CSR_TOTAL_PACKETS: total_in   = csr_wdata;
            CSR_TIMEOUT_POLLS: timeout_in = csr_wdata[7:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               func_in  = req_tuser;
               ack_in   = req_tdata;
               state_in = ST_DECODE;
            end
         end

         // Dispatch on the opcode; the slot at send_seq is read here for a send.
         ST_DECODE: begin
            rd_addr    = send_ff;
            granted_in = 1'b0;
            wire_in    = 6'd0;
            tout_in    = 1'b0;
            cnt_in     = '0;
            step_in    = '0;
            state_in   = ST_FINISH;
            case (func_ff)
               FUNC_SEND: begin
                  state_in = ST_SEND_CHK;
               end
               FUNC_ACK: begin
                  if (ack_ok) begin
                     wr_en    = 1'b1;
                     wr_addr  = ack_slot;
                     wr_data  = MARK_ACKED;
                     wait_in  = 8'd0;
                     state_in = ST_SLIDE_RD;
                  end
               end
               FUNC_POLL: begin
                  if (poll_next > {1'b0, timeout_ff}) begin
                     ptr_in   = base_ff;
                     state_in = ST_SCAN_RD;
                  end else begin
                     wait_in = poll_next[7:0];
                  end
               end
               default: ;
            endcase
         end

         // Grant when inside the window, the slot is sendable and within budget.
         ST_SEND_CHK: begin
            state_in = ST_FINISH;
            if ((8'(seq_dist(base_ff, send_ff)) < 8'(WINDOW)) &&
                (rd_mark == MARK_FREE || rd_mark == MARK_RESEND) &&
                (sent_ff <= (17'(total_ff) + 17'(WINDOW)))) begin
               granted_in = 1'b1;
               wire_in    = 6'({1'b0, send_ff} + (SEQ_W + 1)'(1));
               wr_en      = 1'b1;
               wr_addr    = send_ff;
               wr_data    = MARK_SENT;
               send_in    = seq_inc(send_ff);
               if (sent_ff != SENT_MAX) begin
                  sent_in = sent_ff + 17'd1;
               end
            end
         end

         ST_SLIDE_RD: begin
            rd_addr  = base_ff;
            state_in = ST_SLIDE_CHK;
         end

         // Free an acked base slot and move the base on.
         ST_SLIDE_CHK: begin
            if (rd_mark == MARK_ACKED && step_ff < CNT_W'(SEQ_COUNT)) begin
               wr_en    = 1'b1;
               wr_addr  = base_ff;
               wr_data  = MARK_FREE;
               base_in  = seq_inc(base_ff);
               step_in  = step_ff + 1'b1;
               state_in = ST_SLIDE_RD;
            end else begin
               state_in = ST_FINISH;
            end
         end

         ST_SCAN_RD: begin
            rd_addr  = ptr_ff;
            state_in = ST_SCAN_CHK;
         end

         // Mark unacked window slots for resend, then rewind.
         ST_SCAN_CHK: begin
            if (rd_mark == MARK_SENT) begin
               wr_en   = 1'b1;
               wr_addr = ptr_ff;
               wr_data = MARK_RESEND;
               cnt_in  = cnt_ff + 1'b1;
            end
            ptr_in  = seq_inc(ptr_ff);
            step_in = step_ff + 1'b1;
            if (step_ff == CNT_W'(SPAN - 1)) begin
               sent_in  = (sent_ff > 17'(cnt_in)) ? sent_ff - 17'(cnt_in) : 17'd0;
               send_in  = base_ff;
               wait_in  = 8'd0;
               tout_in  = 1'b1;
               state_in = ST_FINISH;
            end else begin
               state_in = ST_SCAN_RD;
            end
         end

         // Load the response word once the output register is free.
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0, resend_sat, tout_ff, 5'(send_ff), 5'(base_ff),
                               wire_ff, granted_ff};
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state with synchronous reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         base_ff      <= '0;
         send_ff      <= '0;
         sent_ff      <= '0;
         wait_ff      <= '0;
         total_ff     <= '0;
         timeout_ff   <= TIMEOUT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         send_ff      <= send_in;
         sent_ff      <= sent_in;
         wait_ff      <= wait_in;
         total_ff     <= total_in;
         timeout_ff   <= timeout_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      ack_ff      <= ack_in;
      ptr_ff      <= ptr_in;
      step_ff     <= step_in;
      cnt_ff      <= cnt_in;
      granted_ff  <= granted_in;
      wire_ff     <= wire_in;
      tout_ff     <= tout_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

/* rtl/srsw_port_checker.sv */
// Port checker for the send window core and its bind to the top level.
`include "selective_repeat_send_window_core_defines.svh"

module srsw_port_checker
   import srsw_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // A stalled response word stays put.
   `SRSW_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready,
                     rsp_tvalid && $stable(rsp_tdata),
                     "response word changed while stalled")

   // The block is not ready in the cycle after it takes a request.
   `SRSW_ASSERT_NEXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready,
                     "request accepted back to back")

   // A granted send never reports a timeout or resends.
   `SRSW_ASSERT_NOW(a_grant_no_timeout, rsp_tvalid && rsp_tdata[0],
                    !rsp_tdata[17] && (rsp_tdata[22:18] == 5'd0),
                    "grant combined with timeout")

   // Resends are only reported together with a timeout.
   `SRSW_ASSERT_NOW(a_resend_needs_timeout, rsp_tvalid && !rsp_tdata[17],
                    rsp_tdata[22:18] == 5'd0,
                    "resend count without timeout")

endmodule

bind selective_repeat_send_window_core srsw_port_checker u_port_checker (.*);

/* bench/srsw_window_checker.sv */
// Checker for the send window core: predicts every response word and compares it.
`timescale 1ns / 1ps

module srsw_window_checker
   import srsw_pkg::*;
#(
   parameter int SEQ_COUNT = 32,
   parameter int WINDOW    = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [REQ_USER_W-1:0] req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic                  csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    outstanding,
   output int                    words_checked,
   output int                    grants_seen,
   output int                    timeouts_seen
);

   // Response word layout, lowest bit last in the list.
   typedef struct packed {
      logic       pad;
      logic [4:0] resend_count;
      logic       timed_out;
      logic [4:0] next_seq;
      logic [4:0] window_base;
      logic [5:0] send_seq_wire;
      logic       send_granted;
   } window_word_t;

   // Predicted window state and configuration.
   mark_type     slot_marks[SEQ_COUNT];
   int           base_slot;
   int           next_slot;
   int           sent_total;
   int           wait_polls;
   int           packet_budget;
   int           poll_limit;
   window_word_t pending_words[$];
   int           mismatches;
   int           checked;
   int           grants;
   int           timeouts;

   assign fail_count    = mismatches;
   assign words_checked = checked;
   assign grants_seen   = grants;
   assign timeouts_seen = timeouts;

   function automatic int seq_gap(input int from_slot, input int to_slot);
      return (to_slot + SEQ_COUNT - from_slot) % SEQ_COUNT;
   endfunction

   // Applies one request to the predicted window and returns the response it gives.
   function automatic window_word_t advance_window(input logic [1:0] op,
                                                   input logic [7:0] ack_byte);
      window_word_t w;
      int           ack_slot;
      int           wait_next;
      int           marked;
      int           span;
      int           slot;
      int           i;
      w = '0;
      marked = 0;
      case (op)
         FUNC_SEND: begin
            if (seq_gap(base_slot, next_slot) < WINDOW &&
                (slot_marks[next_slot] == MARK_FREE ||
                 slot_marks[next_slot] == MARK_RESEND) &&
                sent_total <= packet_budget + WINDOW) begin
               w.send_granted = 1'b1;
               w.send_seq_wire = 6'(next_slot + 1);
               slot_marks[next_slot] = MARK_SENT;
               next_slot = (next_slot + 1) % SEQ_COUNT;
               if (sent_total < int'(SENT_MAX))
                  sent_total++;
            end
         end
         FUNC_ACK: begin
            // A zero byte carries no ack; out-of-window numbers are dropped.
            if (ack_byte != 8'd0) begin
               ack_slot = int'(ack_byte) - 1;
               if (ack_slot < SEQ_COUNT && seq_gap(base_slot, ack_slot) < WINDOW) begin
                  slot_marks[ack_slot] = MARK_ACKED;
                  for (i = 0; i < SEQ_COUNT && slot_marks[base_slot] == MARK_ACKED; i++) begin
                     slot_marks[base_slot] = MARK_FREE;
                     base_slot = (base_slot + 1) % SEQ_COUNT;
                  end
                  wait_polls = 0;
               end
            end
         end
         FUNC_POLL: begin
            wait_next = wait_polls + 1;
            if (wait_next > poll_limit) begin
               // Timeout: everything still unacked in the window goes back for resend.
               span = (WINDOW < SEQ_COUNT) ? WINDOW : SEQ_COUNT;
               for (i = 0; i < span; i++) begin
                  slot = (base_slot + i) % SEQ_COUNT;
                  if (slot_marks[slot] == MARK_SENT) begin
                     slot_marks[slot] = MARK_RESEND;
                     marked++;
                  end
               end
               sent_total = (sent_total > marked) ? sent_total - marked : 0;
               next_slot = base_slot;
               wait_polls = 0;
               w.timed_out = 1'b1;
            end else begin
               wait_polls = wait_next & 255;
            end
         end
         default: begin
         end
      endcase
      w.window_base = 5'(base_slot);
      w.next_seq = 5'(next_slot);
      w.resend_count = (marked > 31) ? 5'd31 : 5'(marked);
      return w;
   endfunction

   task automatic check_field(input string label, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s expected %0d, got %0d", $time, label, want, got);
         mismatches++;
      end
   endtask

   // Watch all three ports at each edge: configuration first, then requests, then responses.
   always @(posedge clock) begin
      window_word_t want;
      window_word_t got;
      if (reset) begin
         foreach (slot_marks[i])
            slot_marks[i] = MARK_FREE;
         base_slot = 0;
         next_slot = 0;
         sent_total = 0;
         wait_polls = 0;
         packet_budget = 0;
         poll_limit = int'(TIMEOUT_RESET);
         pending_words.delete();
         mismatches = 0;
         checked = 0;
         grants = 0;
         timeouts = 0;
         outstanding <= 0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_TOTAL_PACKETS: packet_budget = int'(csr_wdata);
               CSR_TIMEOUT_POLLS: poll_limit = int'(csr_wdata[7:0]);
               default: begin
               end
            endcase
         end
         if (req_tvalid && req_tready) begin
            want = advance_window(req_tuser, req_tdata);
            pending_words.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            got = window_word_t'(rsp_tdata);
            if (pending_words.size() == 0) begin
               $display("%0t: response word expected none, got %h", $time, rsp_tdata);
               mismatches++;
            end else begin
               want = pending_words.pop_front();
               check_field("send_granted", int'(want.send_granted), int'(got.send_granted));
               check_field("send_seq_wire", int'(want.send_seq_wire),
                           int'(got.send_seq_wire));
               check_field("window_base", int'(want.window_base), int'(got.window_base));
               check_field("next_seq", int'(want.next_seq), int'(got.next_seq));
               check_field("timed_out", int'(want.timed_out), int'(got.timed_out));
               check_field("resend_count", int'(want.resend_count), int'(got.resend_count));
               check_field("pad bit", int'(want.pad), int'(got.pad));
               checked++;
               if (want.send_granted)
                  grants++;
               if (want.timed_out)
                  timeouts++;
            end
         end
         outstanding <= pending_words.size();
      end
   end

endmodule

/* bench/tb_selective_repeat_send_window_core.sv */
// Testbench top for the send window core: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_selective_repeat_send_window_core;
   import srsw_pkg::*;

   localparam int SEQ_COUNT = 32;
   localparam int WINDOW    = 16;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam int PHASE_COUNT = 7;
   localparam int PHASE_WORDS = 145;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we = 1'b0;
   logic                  csr_addr = 1'b0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int       fail_count;
   int       outstanding;
   int       words_checked;
   int       grants_seen;
   int       timeouts_seen;
   int       words_sent = 0;
   int       csr_writes = 0;
   int       poll_setting = 20;
   bit       quiet = 1'b0;
   logic [4:0] seen_base = '0;

   always #5 clock = ~clock;

   selective_repeat_send_window_core #(
      .SEQ_COUNT(SEQ_COUNT),
      .WINDOW(WINDOW)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_we(csr_we),
      .csr_addr(csr_addr),
      .csr_wdata(csr_wdata)
   );

   srsw_window_checker #(
      .SEQ_COUNT(SEQ_COUNT),
      .WINDOW(WINDOW)
   ) window_check (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_we(csr_we),
      .csr_addr(csr_addr),
      .csr_wdata(csr_wdata),
      .fail_count(fail_count),
      .outstanding(outstanding),
      .words_checked(words_checked),
      .grants_seen(grants_seen),
      .timeouts_seen(timeouts_seen)
   );

   // Offers one request word after a random gap and returns once it is taken.
   // Valid stays high afterward; a drain, or a next call that first waits, lowers it.
   task automatic push_word(input logic [1:0] op, input logic [7:0] ack_byte);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= ack_byte;
      do @(posedge clock); while (!req_tready);
      words_sent++;
   endtask

   // Stops offering words and waits until every response has been taken.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic index, input int value);
      csr_we <= 1'b1;
      csr_addr <= index;
      csr_wdata <= 16'(value);
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (index == CSR_TIMEOUT_POLLS)
         poll_setting = value;
      csr_writes++;
   endtask

   // Mostly sends and in-window acks around the last base seen, plus polls and noise.
   task automatic random_word();
      int       pick;
      int       ack_slot;
      logic [7:0] noise;
      pick = $urandom_range(0, 99);
      noise = 8'($urandom_range(0, 255));
      ack_slot = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, WINDOW - 1);
      ack_slot = (int'(seen_base) + ack_slot) % SEQ_COUNT;
      if (pick < 45)
         push_word(FUNC_SEND, noise);
      else if (pick < 75)
         push_word(FUNC_ACK, 8'(ack_slot + 1));
      else if (pick < 88)
         push_word(FUNC_POLL, noise);
      else if (pick < 93)
         push_word(FUNC_ACK, noise);
      else if (pick < 96)
         push_word(FUNC_ACK, 8'd0);
      else
         push_word(FUNC_UNUSED, noise);
   endtask

   // Response side: a random stall before each word, and the last base seen as a hint.
   initial begin
      int stall;
      while (reset) @(posedge clock);
      forever begin
         stall = quiet ? 0 : $urandom_range(0, 6);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         seen_base <= rsp_tdata[11:7];
      end
   end

   // Hard limit on the run.
   initial begin
      #5_000_000;
      $display("%0t: run did not finish in time", $time);
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      int phase;
      int k;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Default settings: ignored acks, unused opcode, a full window, a refused send,
      // out-of-order acks, an ack of a never-sent slot and a send onto an acked slot.
      push_word(FUNC_POLL, 8'h00);
      push_word(FUNC_ACK, 8'h00);
      push_word(FUNC_ACK, 8'hFF);
      push_word(FUNC_ACK, 8'(SEQ_COUNT + 1));
      push_word(FUNC_UNUSED, 8'hAA);
      repeat (WINDOW + 1) push_word(FUNC_SEND, 8'($urandom_range(0, 255)));
      push_word(FUNC_ACK, 8'd16);
      push_word(FUNC_ACK, 8'd1);
      push_word(FUNC_ACK, 8'd17);
      push_word(FUNC_SEND, 8'h55);
      wait_drained();

      // Zero poll limit: every poll times out, the second one with nothing to mark.
      write_csr(CSR_TIMEOUT_POLLS, 0);
      write_csr(CSR_TOTAL_PACKETS, 65535);
      push_word(FUNC_POLL, 8'hFF);
      push_word(FUNC_POLL, 8'h00);
      repeat (3) push_word(FUNC_SEND, 8'h0F);
      push_word(FUNC_ACK, 8'd32);
      push_word(FUNC_POLL, 8'hF0);
      wait_drained();

      // Random phases, each with its own budget and poll limit.
      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: begin
               write_csr(CSR_TOTAL_PACKETS, 65535);
               write_csr(CSR_TIMEOUT_POLLS, 255);
            end
            1: begin
               write_csr(CSR_TOTAL_PACKETS, 0);
               write_csr(CSR_TIMEOUT_POLLS, 1);
            end
            default: begin
               write_csr(CSR_TOTAL_PACKETS, $urandom_range(0, 80));
               write_csr(CSR_TIMEOUT_POLLS, $urandom_range(1, 12));
            end
         endcase
         for (k = 0; k < PHASE_WORDS; k++) begin
            if (k % 32 == 0)
               quiet <= ($urandom_range(0, 3) == 0);
            // Now and then a run of polls long enough to reach the timeout.
            if ((phase == 0 && k == PHASE_WORDS / 2) ||
                (poll_setting <= 12 && $urandom_range(0, 39) == 0)) begin
               repeat (poll_setting + 1) push_word(FUNC_POLL, 8'($urandom_range(0, 255)));
            end
            random_word();
         end
         wait_drained();
      end

      quiet <= 1'b0;
      repeat (40) @(posedge clock);
      $display("Covered %0d request words and %0d checked responses over %0d csr writes.",
               words_sent, words_checked, csr_writes);
      $display("The window granted %0d sends and fired %0d timeouts.",
               grants_seen, timeouts_seen);
      if (fail_count == 0 && outstanding == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
